// ----- rtl/kfsi_pkg.sv -----
// Shared types, constants and helpers for the keyframe scale interpolator.
`timescale 1ns / 1ps
package kfsi_pkg;

   localparam int MAX_KEYS_DEF = 64;
   localparam int NUM_AXES = 3;
   localparam int TIME_W = 50;
   localparam int PROD_W = 65;
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_UNIT  = 2'd0,
      REG_START = 2'd1,
      REG_END   = 2'd2,
      REG_NONE  = 2'd3
   } reg_type;

   typedef struct packed {
      logic go;
      logic div;
   } lane_ctl_type;

   // floor(p / 2^16), saturated to 32 bits
   function automatic logic signed [31:0] q16_sat(input logic signed [63:0] p);
      logic signed [47:0] fl;
      begin
         fl = 48'(p >>> 16);
         if (fl > 48'sh0000_7FFF_FFFF)
            q16_sat = 32'sh7FFF_FFFF;
         else if (fl < -48'sh0000_8000_0000)
            q16_sat = 32'sh8000_0000;
         else
            q16_sat = fl[31:0];
      end
   endfunction

endpackage

// ----- rtl/kfsi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kfsi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/kfsi_lane.sv -----
// One axis lane: interpolation divide, weight and bone-scale products.
`timescale 1ns / 1ps
module kfsi_lane
   import kfsi_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctl_type              ctl,
   input  logic signed [31:0]        s0,
   input  logic signed [31:0]        s1,
   input  logic [31:0]               delta,
   input  logic signed [TIME_W-1:0]  span,
   input  logic signed [31:0]        weight,
   input  logic signed [31:0]        scale_in,
   output logic                      done,
   output logic signed [31:0]        scale_out
);
   typedef enum logic [5:0] {
      L_IDLE = 6'b000001,
      L_PROD = 6'b000010,
      L_DIV  = 6'b000100,
      L_FIN  = 6'b001000,
      L_MW   = 6'b010000,
      L_MS   = 6'b100000
   } lane_state_type;

   localparam int RW = TIME_W + 1;

   lane_state_type state_ff, state_in;
   logic signed [31:0] s0_ff, res_ff, sw_ff, out_ff;
   logic [32:0] mag_ff;
   logic neg_ff;
   logic [31:0] d_ff;
   logic [TIME_W-1:0] span_ff;
   logic [PROD_W-1:0] num_ff;
   logic [RW-1:0] rem_ff;
   logic [6:0] cnt_ff;
   logic done_ff;
   logic signed [32:0] ds;
   logic [RW-1:0] shifted;
   logic fits;
   logic signed [33:0] sum;

   assign ds = 33'(s1) - 33'(s0);
   assign shifted = {rem_ff[RW-2:0], num_ff[PROD_W-1]};
   assign fits = shifted >= {1'b0, span_ff};
   assign sum = neg_ff ? (34'(s0_ff) - 34'(signed'({1'b0, num_ff[32:0]})))
                       : (34'(s0_ff) + 34'(signed'({1'b0, num_ff[32:0]})));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE: if (ctl.go) state_in = ctl.div ? L_PROD : L_MW;
         L_PROD: state_in = L_DIV;
         L_DIV:  if (cnt_ff == 7'(PROD_W - 1)) state_in = L_FIN;
         L_FIN:  state_in = L_MW;
         L_MW:   state_in = L_MS;
         L_MS:   state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= (state_ff == L_MS);
      end
      case (state_ff)
         L_IDLE: begin
            s0_ff <= s0;
            res_ff <= s1;
            neg_ff <= ds[32];
            mag_ff <= ds[32] ? 33'(-ds) : 33'(ds);
            d_ff <= delta;
            span_ff <= span;
         end
         L_PROD: begin
            num_ff <= PROD_W'({33'd0, d_ff} * {32'd0, mag_ff});
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         L_DIV: begin
            rem_ff <= fits ? (shifted - {1'b0, span_ff}) : shifted;
            num_ff <= {num_ff[PROD_W-2:0], fits};
            cnt_ff <= cnt_ff + 7'd1;
         end
         L_FIN: res_ff <= sum[31:0];
         L_MW:  sw_ff <= q16_sat(64'(res_ff) * 64'(weight));
         L_MS:  out_ff <= q16_sat(64'(scale_in) * 64'(sw_ff));
         default: ;
      endcase
   end

   assign done = done_ff;
   assign scale_out = out_ff;
endmodule

// ----- rtl/keyframe_scale_interpolator.sv -----
// Top level: key table, segment walker, three axis lanes and result merge.
// Load, clear and ignored commands finish at the accepting edge; busy stays low.
// A sample reads, fetches and compares each key walked, then reads and compares the
// wrap segment; the lanes run a 65-step restoring divide when it interpolates.
// The result strobe follows; the receiver cannot stall. Sync reset empties the
// table and restores registers to 1.0, 0, 0; table contents are left as is.
`timescale 1ns / 1ps
module keyframe_scale_interpolator
   import kfsi_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [15:0]        req_key_frame,
   input  logic signed [31:0] req_key_scale_x,
   input  logic signed [31:0] req_key_scale_y,
   input  logic signed [31:0] req_key_scale_z,
   input  logic signed [31:0] req_sample_time,
   input  logic signed [31:0] req_blend_weight,
   input  logic signed [31:0] req_scale_in_x,
   input  logic signed [31:0] req_scale_in_y,
   input  logic signed [31:0] req_scale_in_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_scale_out_x,
   output logic signed [31:0] rsp_scale_out_y,
   output logic signed [31:0] rsp_scale_out_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int DW = 16 + 32 * NUM_AXES;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_FETCH = 5'b00100,
      S_CMP   = 5'b01000,
      S_LANE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [30:0] unit_ff;
   logic signed [31:0] cstart_ff, cend_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [15:0] last_ff;
   logic has_f0_ff, wrap_ff, rsp_valid_ff;
   logic signed [31:0] back_ff [NUM_AXES];
   logic signed [31:0] s0_ff [NUM_AXES];
   logic signed [31:0] s1_ff [NUM_AXES];
   logic signed [31:0] sin_ff [NUM_AXES];
   logic signed [31:0] key_s [NUM_AXES];
   logic signed [31:0] lane_s1 [NUM_AXES];
   logic signed [31:0] lane_out [NUM_AXES];
   logic [NUM_AXES-1:0] lane_done;
   logic signed [31:0] t_ff, w_ff;
   logic signed [TIME_W-1:0] t0_ff, t1_ff, t_ext;
   logic accept, load_ok, ge, lt, eq;
   logic [DW-1:0] rd_data;
   lane_ctl_type ctl;
   logic [31:0] delta;
   logic signed [TIME_W-1:0] span;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign key_s[0] = req_key_scale_x;
   assign key_s[1] = req_key_scale_y;
   assign key_s[2] = req_key_scale_z;
   assign load_ok = accept && (req_command == CMD_LOAD) && (count_ff < CW'(MAX_KEYS))
                    && ((count_ff == '0) || (req_key_frame > last_ff));

   always_comb begin
      case (reg_type'(paddr[3:2]))
         REG_UNIT:  prdata = {1'b0, unit_ff};
         REG_START: prdata = cstart_ff;
         REG_END:   prdata = cend_ff;
         default:   prdata = '0;
      endcase
   end

   kfsi_ram #(.WIDTH(DW), .DEPTH(MAX_KEYS)) u_ram (
      .clock  (clock),
      .wr_en  (load_ok),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data({req_key_frame, req_key_scale_x, req_key_scale_y, req_key_scale_z}),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign t_ext = TIME_W'(t_ff);
   assign ge = t_ext >= t0_ff;
   assign lt = t_ext < t1_ff;
   assign eq = t_ext == t1_ff;
   assign delta = 32'(t_ext - t0_ff);
   assign span = t1_ff - t0_ff;

   always_comb begin
      ctl.go = 1'b0;
      ctl.div = 1'b0;
      if (state_ff == S_CMP) begin
         if (ge && lt) begin
            ctl.go = 1'b1;
            ctl.div = 1'b1;
         end else if (eq || wrap_ff) begin
            ctl.go = 1'b1;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++)
         lane_s1[a] = (!(ge && lt) && !eq) ? ONE_Q16 : s1_ff[a];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept && req_command == CMD_SAMPLE) state_in = S_READ;
         S_READ:  state_in = (idx_ff == count_ff) ? S_CMP : S_FETCH;
         S_FETCH: state_in = S_CMP;
         S_CMP:   state_in = ctl.go ? S_LANE : S_READ;
         S_LANE:  if (&lane_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         has_f0_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unit_ff <= 31'd65536;
         cstart_ff <= '0;
         cend_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == S_LANE) && (&lane_done);
         if (psel && penable && pwrite) begin
            case (reg_type'(paddr[3:2]))
               REG_UNIT:  unit_ff <= pwdata[30:0];
               REG_START: cstart_ff <= pwdata;
               REG_END:   cend_ff <= pwdata;
               default: ;
            endcase
         end
         if (accept && req_command == CMD_CLEAR) begin
            count_ff <= '0;
            has_f0_ff <= 1'b0;
         end
         if (load_ok) begin
            count_ff <= count_ff + CW'(1);
            if (count_ff == '0)
               has_f0_ff <= (req_key_frame == 16'd0);
         end
      end
      if (load_ok) begin
         last_ff <= req_key_frame;
         if (count_ff == '0)
            for (int a = 0; a < NUM_AXES; a++) back_ff[a] <= key_s[a];
      end
      case (state_ff)
         S_IDLE: begin
            t_ff <= req_sample_time;
            w_ff <= req_blend_weight;
            sin_ff[0] <= req_scale_in_x;
            sin_ff[1] <= req_scale_in_y;
            sin_ff[2] <= req_scale_in_z;
            t0_ff <= '0;
            idx_ff <= '0;
            wrap_ff <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) s0_ff[a] <= ONE_Q16;
         end
         S_READ: if (idx_ff == count_ff) begin
            wrap_ff <= 1'b1;
            t1_ff <= TIME_W'(cend_ff);
            for (int a = 0; a < NUM_AXES; a++)
               s1_ff[a] <= has_f0_ff ? back_ff[a] : ONE_Q16;
         end
         S_FETCH: begin
            t1_ff <= TIME_W'({1'b0, 47'(rd_data[DW-1:DW-16]) * 47'(unit_ff)})
                     - TIME_W'(cstart_ff);
            s1_ff[0] <= rd_data[95:64];
            s1_ff[1] <= rd_data[63:32];
            s1_ff[2] <= rd_data[31:0];
         end
         S_CMP: if (!ctl.go) begin
            t0_ff <= t1_ff;
            idx_ff <= idx_ff + CW'(1);
            for (int a = 0; a < NUM_AXES; a++) s0_ff[a] <= s1_ff[a];
         end
         default: ;
      endcase
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      kfsi_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .s0       (s0_ff[g]),
         .s1       (lane_s1[g]),
         .delta    (delta),
         .span     (span),
         .weight   (w_ff),
         .scale_in (sin_ff[g]),
         .done     (lane_done[g]),
         .scale_out(lane_out[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scale_out_x = lane_out[0];
   assign rsp_scale_out_y = lane_out[1];
   assign rsp_scale_out_z = lane_out[2];

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS)) else $error("key count overflow");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE)) else $error("result while walking");
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_SAMPLE) |=> busy) else $error("sample not started");
   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      (|lane_done) |-> (&lane_done)) else $error("lanes out of step");
endmodule
